// ===== design/kllm_pkg.sv =====
// Package for the keyed linked list manager: pool size, link widths,
// command and status codes, beat structs, the FSM state type and the memory request.
// No dependencies.
package kllm_pkg;

    // Pool size and derived widths; a link holds a node number or the null value
    localparam int NODES  = 16;
    localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LINK_W = $clog2(NODES + 1);
    localparam int STEP_W = $clog2(NODES + 1);
    localparam int KEY_W  = 32;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NODES);

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_FIND = 2'd2
    } cmd_e;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_ZERO     = 3'd1,
        STAT_EXISTS   = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_e;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] node_index;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DECIDE,
        S_FREE,
        S_LINK,
        S_OUT
    } state_e;

    // One cycle's access to the node memories
    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              key_we;
        logic              next_we;
        logic [NODE_W-1:0] wr_addr;
        logic [KEY_W-1:0]  key_wdata;
        logic [LINK_W-1:0] next_wdata;
    } mem_req_t;

endpackage

// ===== design/kllm_mem.sv =====
// Node memories of the keyed linked list manager: key store and next-link store,
// one write and one registered read per cycle. Depends on kllm_pkg.
module kllm_mem
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  kllm_pkg::mem_req_t        req,
    output logic [kllm_pkg::KEY_W-1:0]  rd_key,
    output logic [kllm_pkg::LINK_W-1:0] rd_next
);

    logic [kllm_pkg::KEY_W-1:0]  key_mem  [kllm_pkg::NODES];
    logic [kllm_pkg::LINK_W-1:0] next_mem [kllm_pkg::NODES];
    logic [kllm_pkg::NODES-1:0]  next_vld_reg;

    logic [kllm_pkg::KEY_W-1:0]  rd_key_reg;
    logic [kllm_pkg::LINK_W-1:0] rd_next_reg;
    logic                        rd_vld_reg;
    logic [kllm_pkg::NODE_W-1:0] rd_addr_reg;

    // Write and read the arrays
    always_ff @(posedge clk)
    begin
        if (req.key_we)
        begin
            key_mem[req.wr_addr] <= req.key_wdata;
        end
        if (req.next_we)
        begin
            next_mem[req.wr_addr] <= req.next_wdata;
        end
        if (req.rd_en)
        begin
            rd_key_reg  <= key_mem[req.rd_addr];
            rd_next_reg <= next_mem[req.rd_addr];
            rd_vld_reg  <= next_vld_reg[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
        end
    end

    // Mark link entries once written; unwritten ones hold the reset chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_vld_reg <= '0;
        end
        else if (req.next_we)
        begin
            next_vld_reg[req.wr_addr] <= 1'b1;
        end
    end

    // Node i links to i+1 until its entry is first written
    assign rd_key  = rd_key_reg;
    assign rd_next = rd_vld_reg ? rd_next_reg
                                : (kllm_pkg::LINK_W'(rd_addr_reg) + kllm_pkg::LINK_W'(1));

endmodule

// ===== design/keyed_linked_list_manager_top.sv =====
// Top level of the keyed linked list manager: command sequencer, list and free heads,
// output register. Depends on kllm_pkg and kllm_mem.
//
// Usage:
//   Input channel in_valid / in_ready / in_data carries one command beat
//   (add, delete or find, with a 32-bit key). Output channel out_valid /
//   out_ready / out_data returns exactly one beat per command: a status and
//   the node index used, freed or found (zero unless status is ok).
//   One command is processed at a time. A zero key or an unused command
//   goes from the accept cycle straight to output; an add or delete that
//   walks the whole list visits up to NODES nodes in turn: the accept
//   cycle, the walk over the visited nodes, then decide, the free-node take
//   (add only), link update and output. The walk follows one link per
//   cycle through the next-link memory with its registered read. The result
//   beat comes up in the same cycle in which in_ready rises again.
//   Reset empties the list and chains all nodes into the free list at once;
//   per-entry valid bits stand in for the initial link values, so no
//   clearing pass is needed and a command is taken right after reset.
//   A finished result waits in the output register; a new command is taken
//   while it waits, and that command's result stalls only at its end until
//   the receiver takes the previous beat.
module keyed_linked_list_manager_top
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  kllm_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output kllm_pkg::out_t  out_data
);

    kllm_pkg::state_e state_reg, state_next;

    logic [1:0]                  cmd_reg, cmd_next;
    logic [kllm_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [kllm_pkg::LINK_W-1:0] list_head_reg, list_head_next;
    logic [kllm_pkg::LINK_W-1:0] free_head_reg, free_head_next;
    logic [kllm_pkg::NODE_W-1:0] cur_reg, cur_next;
    logic [kllm_pkg::LINK_W-1:0] last_reg, last_next;
    logic [kllm_pkg::LINK_W-1:0] after_reg, after_next;
    logic [kllm_pkg::LINK_W-1:0] link_val_reg, link_val_next;
    logic [kllm_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic                        found_reg, found_next;
    logic [kllm_pkg::NODE_W-1:0] node_reg, node_next;
    kllm_pkg::status_e           status_reg, status_next;
    logic                        out_valid_reg, out_valid_next;
    kllm_pkg::out_t              out_data_reg, out_data_next;

    kllm_pkg::mem_req_t          mem_req;
    logic [kllm_pkg::KEY_W-1:0]  rd_key;
    logic [kllm_pkg::LINK_W-1:0] rd_next;

    logic accept;
    logic key_hit;
    logic walk_end;
    logic out_free;
    logic head_nil;
    logic free_nil;
    logic last_nil;

    kllm_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_key  (rd_key),
        .rd_next (rd_next)
    );

    assign in_ready  = (state_reg == kllm_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign key_hit   = (rd_key == key_reg);
    assign walk_end  = (rd_next >= kllm_pkg::NIL_LINK)
                    || (steps_reg == kllm_pkg::STEP_W'(kllm_pkg::NODES));
    assign head_nil  = (list_head_reg >= kllm_pkg::NIL_LINK);
    assign free_nil  = (free_head_reg >= kllm_pkg::NIL_LINK);
    assign last_nil  = (last_reg >= kllm_pkg::NIL_LINK);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kllm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.command != kllm_pkg::CMD_ADD
                        && in_data.command != kllm_pkg::CMD_DEL
                        && in_data.command != kllm_pkg::CMD_FIND)
                    begin
                        state_next = kllm_pkg::S_OUT;
                    end
                    else if (in_data.key == '0)
                    begin
                        state_next = kllm_pkg::S_OUT;
                    end
                    else if (head_nil)
                    begin
                        state_next = kllm_pkg::S_DECIDE;
                    end
                    else
                    begin
                        state_next = kllm_pkg::S_WALK;
                    end
                end
            end
            kllm_pkg::S_WALK:
            begin
                if (key_hit || walk_end)
                begin
                    state_next = kllm_pkg::S_DECIDE;
                end
            end
            kllm_pkg::S_DECIDE:
            begin
                case (cmd_reg)
                    kllm_pkg::CMD_ADD:
                    begin
                        if (found_reg || free_nil)
                        begin
                            state_next = kllm_pkg::S_OUT;
                        end
                        else
                        begin
                            state_next = kllm_pkg::S_FREE;
                        end
                    end
                    kllm_pkg::CMD_DEL:
                    begin
                        if (found_reg && !last_nil)
                        begin
                            state_next = kllm_pkg::S_LINK;
                        end
                        else
                        begin
                            state_next = kllm_pkg::S_OUT;
                        end
                    end
                    default:
                    begin
                        state_next = kllm_pkg::S_OUT;
                    end
                endcase
            end
            kllm_pkg::S_FREE:
            begin
                if (last_nil)
                begin
                    state_next = kllm_pkg::S_OUT;
                end
                else
                begin
                    state_next = kllm_pkg::S_LINK;
                end
            end
            kllm_pkg::S_LINK:
            begin
                state_next = kllm_pkg::S_OUT;
            end
            kllm_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    state_next = kllm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kllm_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and memory requests
    always_comb
    begin
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        after_next     = after_reg;
        link_val_next  = link_val_reg;
        steps_next     = steps_reg;
        found_next     = found_reg;
        node_next      = node_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        mem_req            = '0;
        mem_req.key_wdata  = key_reg;

        case (state_reg)
            kllm_pkg::S_IDLE:
            begin
                // Latch the command and start the walk at the list head
                if (accept)
                begin
                    cmd_next   = in_data.command;
                    key_next   = in_data.key;
                    last_next  = kllm_pkg::NIL_LINK;
                    found_next = 1'b0;
                    steps_next = kllm_pkg::STEP_W'(1);
                    cur_next   = list_head_reg[kllm_pkg::NODE_W-1:0];
                    if (in_data.command != kllm_pkg::CMD_ADD
                        && in_data.command != kllm_pkg::CMD_DEL
                        && in_data.command != kllm_pkg::CMD_FIND)
                    begin
                        status_next = kllm_pkg::STAT_NOTFOUND;
                    end
                    else if (in_data.key == '0)
                    begin
                        status_next = kllm_pkg::STAT_ZERO;
                    end
                    else if (!head_nil)
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = list_head_reg[kllm_pkg::NODE_W-1:0];
                    end
                end
            end
            kllm_pkg::S_WALK:
            begin
                // Compare one node a cycle, then follow its link
                if (key_hit)
                begin
                    found_next = 1'b1;
                    node_next  = cur_reg;
                    after_next = rd_next;
                end
                else
                begin
                    last_next = kllm_pkg::LINK_W'(cur_reg);
                    if (!walk_end)
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = rd_next[kllm_pkg::NODE_W-1:0];
                        cur_next        = rd_next[kllm_pkg::NODE_W-1:0];
                        steps_next      = steps_reg + kllm_pkg::STEP_W'(1);
                    end
                end
            end
            kllm_pkg::S_DECIDE:
            begin
                case (cmd_reg)
                    kllm_pkg::CMD_ADD:
                    begin
                        if (found_reg)
                        begin
                            status_next = kllm_pkg::STAT_EXISTS;
                        end
                        else if (free_nil)
                        begin
                            status_next = kllm_pkg::STAT_FULL;
                        end
                        else
                        begin
                            // Fetch the successor of the free head
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = free_head_reg[kllm_pkg::NODE_W-1:0];
                        end
                    end
                    kllm_pkg::CMD_DEL:
                    begin
                        if (found_reg)
                        begin
                            // Push the node onto the free list, bypass it in the key list
                            status_next        = kllm_pkg::STAT_OK;
                            mem_req.next_we    = 1'b1;
                            mem_req.wr_addr    = node_reg;
                            mem_req.next_wdata = free_head_reg;
                            free_head_next     = kllm_pkg::LINK_W'(node_reg);
                            link_val_next      = after_reg;
                            if (last_nil)
                            begin
                                list_head_next = after_reg;
                            end
                        end
                        else
                        begin
                            status_next = kllm_pkg::STAT_NOTFOUND;
                        end
                    end
                    default:
                    begin
                        status_next = found_reg ? kllm_pkg::STAT_OK
                                                : kllm_pkg::STAT_NOTFOUND;
                    end
                endcase
            end
            kllm_pkg::S_FREE:
            begin
                // Take the free head as the new tail node
                status_next        = kllm_pkg::STAT_OK;
                node_next          = free_head_reg[kllm_pkg::NODE_W-1:0];
                mem_req.key_we     = 1'b1;
                mem_req.next_we    = 1'b1;
                mem_req.wr_addr    = free_head_reg[kllm_pkg::NODE_W-1:0];
                mem_req.next_wdata = kllm_pkg::NIL_LINK;
                free_head_next     = rd_next;
                link_val_next      = free_head_reg;
                if (last_nil)
                begin
                    list_head_next = free_head_reg;
                end
            end
            kllm_pkg::S_LINK:
            begin
                // Point the predecessor at its new successor
                mem_req.next_we    = 1'b1;
                mem_req.wr_addr    = last_reg[kllm_pkg::NODE_W-1:0];
                mem_req.next_wdata = link_val_reg;
            end
            kllm_pkg::S_OUT:
            begin
                // Hold until the output register is free, then load the beat
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.status  = status_reg;
                    out_data_next.node_index =
                        (status_reg == kllm_pkg::STAT_OK) ? 4'(node_reg) : 4'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kllm_pkg::S_IDLE;
            list_head_reg <= kllm_pkg::NIL_LINK;
            free_head_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        cur_reg      <= cur_next;
        last_reg     <= last_next;
        after_reg    <= after_next;
        link_val_reg <= link_val_next;
        steps_reg    <= steps_next;
        found_reg    <= found_next;
        node_reg     <= node_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

endmodule
